### hdl/ckpc_pkg.sv
package ckpc_pkg;

	localparam int LETTERS     = 26;
	localparam int DIGITS      = 10;
	localparam int KEY_BYTES   = 8;
	localparam int MIN_KEY_LEN = 4;

	localparam logic [7:0] ASCII_LA   = 8'h61;
	localparam logic [7:0] ASCII_LZ   = 8'h7a;
	localparam logic [7:0] ASCII_UA   = 8'h41;
	localparam logic [7:0] ASCII_UZ   = 8'h5a;
	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_NINE = 8'h39;
	localparam logic [7:0] ASCII_NL   = 8'h0a;
	localparam logic [7:0] ASCII_NUL  = 8'h00;

	localparam logic [1:0] REG_KEY  = 2'd0;
	localparam logic [1:0] REG_MODE = 2'd1;

	typedef logic [4:0] letter_t;
	typedef logic [3:0] digit_t;
	typedef logic [LETTERS-1:0][4:0] alpha_tab_t;

	typedef struct packed {
		letter_t letter_shift;
		digit_t  digit_shift;
		logic    key_short;
	} key_info_t;

	function automatic letter_t mod26_add(input letter_t a, input letter_t b);
		logic [5:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= 6'(LETTERS)) begin
			s = s - 6'(LETTERS);
		end
		return s[4:0];
	endfunction

	function automatic letter_t mod26_sub(input letter_t a, input letter_t b);
		logic [5:0] s;
		s = {1'b0, a} + 6'(LETTERS) - {1'b0, b};
		if (s >= 6'(LETTERS)) begin
			s = s - 6'(LETTERS);
		end
		return s[4:0];
	endfunction

	function automatic digit_t mod10_add(input digit_t a, input digit_t b);
		logic [4:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= 5'(DIGITS)) begin
			s = s - 5'(DIGITS);
		end
		return s[3:0];
	endfunction

	function automatic digit_t mod10_sub(input digit_t a, input digit_t b);
		logic [4:0] s;
		s = {1'b0, a} + 5'(DIGITS) - {1'b0, b};
		if (s >= 5'(DIGITS)) begin
			s = s - 5'(DIGITS);
		end
		return s[3:0];
	endfunction

endpackage

### hdl/ckpc_key_deriv.sv
module ckpc_key_deriv (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [63:0]             key_data,
	output logic                    busy,
	output ckpc_pkg::key_info_t     key_info,
	output ckpc_pkg::alpha_tab_t    fwd_tab,
	output ckpc_pkg::alpha_tab_t    inv_tab
);

	typedef enum logic [2:0] {
		KD_IDLE  = 3'b001,
		KD_BYTES = 3'b010,
		KD_FILL  = 3'b100
	} kd_state_t;

	kd_state_t                state_q;
	logic [4:0]               cnt_q;
	logic [63:0]              key_q;
	logic                     ended_q;
	logic [3:0]               len_q;
	logic [ckpc_pkg::LETTERS-1:0] used_q;
	ckpc_pkg::letter_t        n_q;
	ckpc_pkg::letter_t        sum26_q;
	ckpc_pkg::digit_t         sum10_q;
	ckpc_pkg::alpha_tab_t     fwd_q;
	ckpc_pkg::alpha_tab_t     inv_q;

	logic [7:0]               kbyte;
	logic                     is_digit;
	logic                     is_lower;
	logic                     is_upper;
	ckpc_pkg::letter_t        lidx;
	ckpc_pkg::digit_t         dval;

	assign kbyte    = key_q[7:0];
	assign is_digit = (kbyte >= ckpc_pkg::ASCII_ZERO) && (kbyte <= ckpc_pkg::ASCII_NINE);
	assign is_lower = (kbyte >= ckpc_pkg::ASCII_LA) && (kbyte <= ckpc_pkg::ASCII_LZ);
	assign is_upper = (kbyte >= ckpc_pkg::ASCII_UA) && (kbyte <= ckpc_pkg::ASCII_UZ);

	always_comb begin
		logic [7:0] diff;
		diff = is_lower ? (kbyte - ckpc_pkg::ASCII_LA) : (kbyte - ckpc_pkg::ASCII_UA);
		lidx = diff[4:0];
		diff = kbyte - ckpc_pkg::ASCII_ZERO;
		dval = diff[3:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= KD_IDLE;
			cnt_q   <= '0;
			key_q   <= '0;
			ended_q <= 1'b0;
			len_q   <= '0;
			used_q  <= '0;
			n_q     <= '0;
			sum26_q <= '0;
			sum10_q <= '0;
			for (int i = 0; i < ckpc_pkg::LETTERS; i++) begin
				fwd_q[i] <= 5'(i);
				inv_q[i] <= 5'(i);
			end
		end else if (start) begin
			state_q <= KD_BYTES;
			cnt_q   <= '0;
			key_q   <= key_data;
			ended_q <= 1'b0;
			len_q   <= '0;
			used_q  <= '0;
			n_q     <= '0;
			sum26_q <= '0;
			sum10_q <= '0;
		end else begin
			unique case (state_q)
				KD_IDLE: begin
				end
				KD_BYTES: begin
					// one key byte a cycle, low byte first; a zero byte ends the key
					if (!ended_q && kbyte != ckpc_pkg::ASCII_NUL) begin
						len_q <= len_q + 4'd1;
						if (is_digit) begin
							sum26_q <= ckpc_pkg::mod26_add(sum26_q, {1'b0, dval});
							sum10_q <= ckpc_pkg::mod10_add(sum10_q, dval);
						end else if ((is_lower || is_upper) && !used_q[lidx]) begin
							used_q[lidx] <= 1'b1;
							fwd_q[n_q]   <= lidx;
							inv_q[lidx]  <= n_q;
							n_q          <= n_q + 5'd1;
						end
					end
					if (kbyte == ckpc_pkg::ASCII_NUL) begin
						ended_q <= 1'b1;
					end
					key_q <= key_q >> 8;
					if (cnt_q == 5'(ckpc_pkg::KEY_BYTES - 1)) begin
						cnt_q   <= '0;
						state_q <= KD_FILL;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				KD_FILL: begin
					// append the letters the key did not use, in order
					if (!used_q[cnt_q]) begin
						fwd_q[n_q]   <= cnt_q;
						inv_q[cnt_q] <= n_q;
						n_q          <= n_q + 5'd1;
					end
					if (cnt_q == 5'(ckpc_pkg::LETTERS - 1)) begin
						cnt_q   <= '0;
						state_q <= KD_IDLE;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				default: begin
					state_q <= KD_IDLE;
				end
			endcase
		end
	end

	assign busy                  = (state_q != KD_IDLE);
	assign key_info.letter_shift = (sum26_q == '0) ? 5'd1 : sum26_q;
	assign key_info.digit_shift  = (sum10_q == '0) ? 4'd1 : sum10_q;
	assign key_info.key_short    = (len_q < 4'(ckpc_pkg::MIN_KEY_LEN));
	assign fwd_tab               = fwd_q;
	assign inv_tab               = inv_q;

endmodule

### hdl/ckpc_cipher.sv
module ckpc_cipher (
	input  logic                    decrypt,
	input  ckpc_pkg::key_info_t     key_info,
	input  ckpc_pkg::alpha_tab_t    fwd_tab,
	input  ckpc_pkg::alpha_tab_t    inv_tab,
	input  logic [7:0]              char_i,
	input  ckpc_pkg::letter_t       pos26,
	input  ckpc_pkg::digit_t        pos10,
	output logic [7:0]              char_o
);

	logic               is_lower;
	logic               is_upper;
	logic               is_digit;
	logic [7:0]         base;
	logic [7:0]         diff;
	ckpc_pkg::letter_t  x_in;
	ckpc_pkg::letter_t  x_shift;
	ckpc_pkg::letter_t  x_sub;
	ckpc_pkg::letter_t  x_out;
	ckpc_pkg::digit_t   d_in;
	ckpc_pkg::digit_t   d_out;

	assign is_lower = (char_i >= ckpc_pkg::ASCII_LA) && (char_i <= ckpc_pkg::ASCII_LZ);
	assign is_upper = (char_i >= ckpc_pkg::ASCII_UA) && (char_i <= ckpc_pkg::ASCII_UZ);
	assign is_digit = (char_i >= ckpc_pkg::ASCII_ZERO) && (char_i <= ckpc_pkg::ASCII_NINE);

	assign base = is_lower ? ckpc_pkg::ASCII_LA :
	              is_upper ? ckpc_pkg::ASCII_UA : ckpc_pkg::ASCII_ZERO;
	assign diff = char_i - base;
	assign x_in = diff[4:0];
	assign d_in = diff[3:0];

	// encrypt: shift, substitute, position; decrypt walks it backwards
	always_comb begin
		if (!decrypt) begin
			x_shift = ckpc_pkg::mod26_add(x_in, key_info.letter_shift);
			x_sub   = fwd_tab[x_shift];
			x_out   = ckpc_pkg::mod26_add(x_sub, pos26);
			d_out   = ckpc_pkg::mod10_add(ckpc_pkg::mod10_add(d_in, key_info.digit_shift), pos10);
		end else begin
			x_shift = ckpc_pkg::mod26_sub(x_in, pos26);
			x_sub   = inv_tab[x_shift];
			x_out   = ckpc_pkg::mod26_sub(x_sub, key_info.letter_shift);
			d_out   = ckpc_pkg::mod10_sub(ckpc_pkg::mod10_sub(d_in, key_info.digit_shift), pos10);
		end
	end

	always_comb begin
		char_o = char_i;
		if (!key_info.key_short) begin
			if (is_lower || is_upper) begin
				char_o = base + {3'b000, x_out};
			end else if (is_digit) begin
				char_o = base + {4'b0000, d_out};
			end
		end
	end

endmodule

### hdl/caesar_keyword_position_cipher.sv
// An accepted item passes through the input register and then the result register to its result.
// Throughput: one item per cycle while in_stall is low; the result register lets a new item in while a result waits.
// A write of the key register starts a derivation of the alphabet tables (8 key bytes, then 26 letters);
// in_stall is high while it runs.
// Reset clears line and column, zero key (identity alphabet, both shifts 1, key flagged short),
// encrypt mode, and empties both stages.
module caesar_keyword_position_cipher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_in,
	input  logic        message_start,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  char_out,
	output logic        key_error
);

	logic                  decrypt_q;
	logic                  key_start;
	logic                  key_busy;
	ckpc_pkg::key_info_t   key_info;
	ckpc_pkg::alpha_tab_t  fwd_tab;
	ckpc_pkg::alpha_tab_t  inv_tab;

	// line and line+column, held as residues mod 26 and mod 10 (together mod 130)
	ckpc_pkg::letter_t     line26_q;
	ckpc_pkg::digit_t      line10_q;
	ckpc_pkg::letter_t     pos26_q;
	ckpc_pkg::digit_t      pos10_q;
	ckpc_pkg::letter_t     line26_eff;
	ckpc_pkg::digit_t      line10_eff;
	ckpc_pkg::letter_t     pos26_eff;
	ckpc_pkg::digit_t      pos10_eff;
	ckpc_pkg::letter_t     line26_nx;
	ckpc_pkg::digit_t      line10_nx;

	logic                  valid_s1;
	logic [7:0]            char_s1;
	ckpc_pkg::letter_t     pos26_s1;
	ckpc_pkg::digit_t      pos10_s1;

	logic                  out_valid_q;
	logic [7:0]            char_out_q;
	logic                  key_error_q;

	logic                  in_accept;
	logic                  out_ready;
	logic                  move_s1;
	logic [7:0]            char_res;

	assign key_start = cfg_we && (cfg_index == ckpc_pkg::REG_KEY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decrypt_q <= 1'b0;
		end else if (cfg_we && cfg_index == ckpc_pkg::REG_MODE) begin
			decrypt_q <= cfg_data[0];
		end
	end

	ckpc_key_deriv u_key (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (key_start),
		.key_data (cfg_data),
		.busy     (key_busy),
		.key_info (key_info),
		.fwd_tab  (fwd_tab),
		.inv_tab  (inv_tab)
	);

	assign out_ready = !out_valid_q || !out_stall;
	assign move_s1   = valid_s1 && out_ready;
	assign in_stall  = key_busy || (valid_s1 && !out_ready);
	assign in_accept = in_valid && !in_stall;

	assign line26_eff = message_start ? '0 : line26_q;
	assign line10_eff = message_start ? '0 : line10_q;
	assign pos26_eff  = message_start ? '0 : pos26_q;
	assign pos10_eff  = message_start ? '0 : pos10_q;
	assign line26_nx  = ckpc_pkg::mod26_add(line26_eff, 5'd1);
	assign line10_nx  = ckpc_pkg::mod10_add(line10_eff, 4'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line26_q <= '0;
			line10_q <= '0;
			pos26_q  <= '0;
			pos10_q  <= '0;
		end else if (in_accept) begin
			if (char_in == ckpc_pkg::ASCII_NL) begin
				line26_q <= line26_nx;
				line10_q <= line10_nx;
				pos26_q  <= line26_nx;
				pos10_q  <= line10_nx;
			end else begin
				line26_q <= line26_eff;
				line10_q <= line10_eff;
				pos26_q  <= ckpc_pkg::mod26_add(pos26_eff, 5'd1);
				pos10_q  <= ckpc_pkg::mod10_add(pos10_eff, 4'd1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			char_s1  <= char_in;
			pos26_s1 <= pos26_eff;
			pos10_s1 <= pos10_eff;
		end
	end

	ckpc_cipher u_cipher (
		.decrypt  (decrypt_q),
		.key_info (key_info),
		.fwd_tab  (fwd_tab),
		.inv_tab  (inv_tab),
		.char_i   (char_s1),
		.pos26    (pos26_s1),
		.pos10    (pos10_s1),
		.char_o   (char_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			char_out_q  <= char_res;
			key_error_q <= key_info.key_short;
		end
	end

	assign out_valid = out_valid_q;
	assign char_out  = char_out_q;
	assign key_error = key_error_q;

endmodule

### tb/caesar_keyword_position_cipher_tb.sv
`timescale 1ns / 1ps

module caesar_keyword_position_cipher_tb;
	import ckpc_pkg::*;

	localparam int POS_WRAP = 130;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [1:0] REG_UNUSED_LO = 2'd2;
	localparam logic [1:0] REG_UNUSED_HI = 2'd3;
	localparam logic [63:0] DIRECTED_KEY = 64'h31783941_63336241; // "Ab3cA9x1"

	typedef struct {
		logic [7:0] ch;
		logic       start;
	} text_byte_t;

	typedef struct {
		logic [7:0] ch;
		logic       err;
	} cipher_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  char_in = '0;
	logic        message_start = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  char_out;
	logic        key_error;

	text_byte_t  text_backlog[$];
	cipher_out_t cipher_expected[$];
	cipher_out_t want;
	text_byte_t  next_byte;
	int          send_gap_pct = 0;
	int          recv_gap_pct = 0;
	int          fail_count = 0;
	int          cycles = 0;

	// predictor state
	letter_t kw_fwd [LETTERS];
	letter_t kw_inv [LETTERS];
	int      letter_shift;
	int      digit_shift;
	bit      short_key;
	bit      decipher;
	int      line_no;
	int      pos_total;

	caesar_keyword_position_cipher dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.char_in       (char_in),
		.message_start (message_start),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.char_out      (char_out),
		.key_error     (key_error)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	function automatic void derive_key(input logic [63:0] key);
		bit         seen [LETTERS];
		int         i, n, sum, len, l;
		bit         ended;
		logic [7:0] b;
		n = 0;
		sum = 0;
		len = 0;
		ended = 1'b0;
		for (i = 0; i < LETTERS; i++) begin
			seen[i] = 1'b0;
		end
		for (i = 0; i < KEY_BYTES; i++) begin
			b = key[8*i +: 8];
			if (b == ASCII_NUL) begin
				ended = 1'b1;
			end
			if (!ended) begin
				len++;
				if (b >= ASCII_ZERO && b <= ASCII_NINE) begin
					sum += int'(b - ASCII_ZERO);
				end else if ((b >= ASCII_LA && b <= ASCII_LZ) || (b >= ASCII_UA && b <= ASCII_UZ)) begin
					l = (b >= ASCII_LA) ? int'(b - ASCII_LA) : int'(b - ASCII_UA);
					if (!seen[l]) begin
						seen[l] = 1'b1;
						kw_fwd[n] = letter_t'(l);
						n++;
					end
				end
			end
		end
		for (i = 0; i < LETTERS; i++) begin
			if (!seen[i]) begin
				kw_fwd[n] = letter_t'(i);
				n++;
			end
		end
		for (i = 0; i < LETTERS; i++) begin
			kw_inv[kw_fwd[i]] = letter_t'(i);
		end
		letter_shift = sum % LETTERS;
		if (letter_shift == 0) begin
			letter_shift = 1;
		end
		digit_shift = sum % DIGITS;
		if (digit_shift == 0) begin
			digit_shift = 1;
		end
		short_key = (len < MIN_KEY_LEN);
	endfunction

	function automatic int shift_letter(input int x, input int pos);
		int p, y;
		p = pos % LETTERS;
		if (!decipher) begin
			y = (x + letter_shift) % LETTERS;
			y = int'(kw_fwd[y]);
			y = (y + p) % LETTERS;
		end else begin
			y = (x + LETTERS - p) % LETTERS;
			y = int'(kw_inv[y]);
			y = (y + LETTERS - letter_shift) % LETTERS;
		end
		return y;
	endfunction

	function automatic int shift_digit(input int d, input int pos);
		int p;
		p = pos % DIGITS;
		if (!decipher) begin
			return (d + digit_shift + p) % DIGITS;
		end
		return (d + 2 * DIGITS - digit_shift - p) % DIGITS;
	endfunction

	// updates line/position state and queues the byte the block should emit
	function automatic void predict_cipher_byte(input logic [7:0] c, input logic start);
		cipher_out_t r;
		r.ch = c;
		r.err = short_key;
		if (start) begin
			line_no = 0;
			pos_total = 0;
		end
		if (c == ASCII_NL) begin
			line_no = (line_no + 1) % POS_WRAP;
			pos_total = line_no;
		end else begin
			if (!short_key) begin
				if (c >= ASCII_LA && c <= ASCII_LZ) begin
					r.ch = ASCII_LA + 8'(shift_letter(int'(c - ASCII_LA), pos_total));
				end else if (c >= ASCII_UA && c <= ASCII_UZ) begin
					r.ch = ASCII_UA + 8'(shift_letter(int'(c - ASCII_UA), pos_total));
				end else if (c >= ASCII_ZERO && c <= ASCII_NINE) begin
					r.ch = ASCII_ZERO + 8'(shift_digit(int'(c - ASCII_ZERO), pos_total));
				end
			end
			pos_total = (pos_total + 1) % POS_WRAP;
		end
		cipher_expected.push_back(r);
	endfunction

	// sender
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			char_in <= '0;
			message_start <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_cipher_byte(char_in, message_start);
			end
			if (!in_valid || !in_stall) begin
				if (text_backlog.size() != 0 && $urandom_range(99, 0) >= send_gap_pct) begin
					next_byte = text_backlog.pop_front();
					in_valid <= 1'b1;
					char_in <= next_byte.ch;
					message_start <= next_byte.start;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (cipher_expected.size() == 0) begin
					$display("%0t: unexpected item: expected none, got char_out=%h key_error=%b",
						$time, char_out, key_error);
					fail_count++;
				end else begin
					want = cipher_expected.pop_front();
					if (char_out !== want.ch) begin
						$display("%0t: char_out mismatch: expected %h, got %h",
							$time, want.ch, char_out);
						fail_count++;
					end
					if (key_error !== want.err) begin
						$display("%0t: key_error mismatch: expected %b, got %b",
							$time, want.err, key_error);
						fail_count++;
					end
				end
			end
			out_stall <= ($urandom_range(99, 0) < recv_gap_pct);
		end
	end

	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_KEY) begin
			derive_key(val);
		end else if (idx == REG_MODE) begin
			decipher = val[0];
		end
	endtask

	task automatic push_byte(input logic [7:0] c, input logic start);
		text_byte_t t;
		t.ch = c;
		t.start = start;
		text_backlog.push_back(t);
	endtask

	task automatic push_text(input int count, input int nl_pct, input int start_pct);
		int         i, roll;
		logic [7:0] c;
		for (i = 0; i < count; i++) begin
			roll = $urandom_range(99, 0);
			if (roll < nl_pct) begin
				c = ASCII_NL;
			end else begin
				roll = $urandom_range(99, 0);
				if (roll < 25) begin
					c = ASCII_LA + 8'($urandom_range(25, 0));
				end else if (roll < 45) begin
					c = ASCII_UA + 8'($urandom_range(25, 0));
				end else if (roll < 70) begin
					c = ASCII_ZERO + 8'($urandom_range(9, 0));
				end else begin
					c = 8'($urandom_range(255, 0));
				end
			end
			push_byte(c, $urandom_range(99, 0) < start_pct);
		end
	endtask

	// sampled mid-cycle so the sender's and receiver's updates have settled
	task automatic wait_idle();
		do begin
			@(negedge clk);
		end while (text_backlog.size() != 0 || in_valid || cipher_expected.size() != 0);
	endtask

	function automatic logic [63:0] random_key();
		logic [63:0] k;
		int          i, roll;
		k = '0;
		for (i = 0; i < KEY_BYTES; i++) begin
			roll = $urandom_range(99, 0);
			// few distinct lower-case letters so repeats are common
			if (roll < 30) begin
				k[8*i +: 8] = ASCII_LA + 8'($urandom_range(5, 0));
			end else if (roll < 45) begin
				k[8*i +: 8] = ASCII_UA + 8'($urandom_range(25, 0));
			end else if (roll < 70) begin
				k[8*i +: 8] = ASCII_ZERO + 8'($urandom_range(9, 0));
			end else if (roll < 92) begin
				k[8*i +: 8] = 8'($urandom_range(255, 0));
			end else begin
				k[8*i +: 8] = ASCII_NUL;
			end
		end
		return k;
	endfunction

	initial begin
		logic [63:0] corner_keys [6];
		logic [63:0] key;
		logic [63:0] mode_word;
		int          ph;

		corner_keys[0] = 64'hffff_ffff_ffff_ffff; // no letters or digits, full length
		corner_keys[1] = 64'h0;                   // empty key
		corner_keys[2] = 64'h0000_0000_0063_6261; // three bytes: too short
		corner_keys[3] = 64'h0000_0000_3038_3939; // digit sum 26: letter shift wraps to 0
		corner_keys[4] = 64'h0000_0000_3433_3231; // digit sum 10: digit shift wraps to 0
		corner_keys[5] = 64'h7374_7576_7778_797a; // eight letters, no digits

		derive_key(64'h0);
		decipher = 1'b0;
		line_no = 0;
		pos_total = 0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		send_gap_pct = 19;
		recv_gap_pct = 45;

		// reset key is short: bytes pass through flagged
		push_byte(8'h61, 1'b0);
		push_byte(8'h5a, 1'b0);
		push_byte(8'h35, 1'b0);
		wait_idle();

		write_reg(REG_KEY, DIRECTED_KEY);
		push_byte(ASCII_LA, 1'b0);
		push_byte(ASCII_LZ, 1'b0);
		push_byte(ASCII_UA, 1'b0);
		push_byte(ASCII_UZ, 1'b0);
		push_byte(ASCII_ZERO, 1'b0);
		push_byte(ASCII_NINE, 1'b0);
		push_byte(ASCII_NUL, 1'b0);
		push_byte(8'hff, 1'b0);
		push_byte(8'h40, 1'b0);
		push_byte(8'h5b, 1'b0);
		push_byte(8'h60, 1'b0);
		push_byte(8'h7b, 1'b0);
		push_byte(8'h2f, 1'b0);
		push_byte(8'h3a, 1'b0);
		push_byte(ASCII_NL, 1'b0);
		push_byte(8'h6d, 1'b1);
		wait_idle();

		write_reg(REG_MODE, 64'h1);
		push_byte(ASCII_LA, 1'b1);
		push_byte(ASCII_UZ, 1'b0);
		push_byte(ASCII_ZERO, 1'b0);
		push_byte(ASCII_NL, 1'b0);
		push_byte(ASCII_NINE, 1'b0);
		wait_idle();

		for (ph = 0; ph < 16; ph++) begin
			if (ph < 5) begin
				send_gap_pct = 19;
				recv_gap_pct = 45;
			end else if (ph < 10) begin
				send_gap_pct = 45;
				recv_gap_pct = 19;
			end else begin
				send_gap_pct = 0;
				recv_gap_pct = 0;
			end

			if (ph % 3 == 0) begin
				write_reg((ph % 2 != 0) ? REG_UNUSED_HI : REG_UNUSED_LO, {$urandom, $urandom});
			end

			mode_word = {$urandom, $urandom};
			mode_word[0] = (ph < 6) ? ph[0] : 1'($urandom_range(1, 0));
			write_reg(REG_MODE, mode_word);

			if (ph < 6) begin
				key = corner_keys[ph];
			end else if (ph % 4 == 3) begin
				key = {$urandom, $urandom};
			end else begin
				key = random_key();
			end
			write_reg(REG_KEY, key);

			// one phase runs past the line wrap, one runs a single long line
			if (ph == 6) begin
				push_text(150, 90, 0);
			end else if (ph == 7) begin
				push_text(150, 0, 0);
			end else begin
				push_text(25, 8, 5);
			end
			wait_idle();
		end

		repeat (8) @(posedge clk);
		if (fail_count == 0 && cipher_expected.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
